FILE: rtl/ntp_pkg.sv
// Package for the numeric token parser: payload structs, token state struct,
// radix codes and character constants. Used by every file in rtl/.
package ntp_pkg;

   localparam int VALUE_BITS_DEF = 16;
   localparam int OUT_BITS       = 16;
   localparam int LEN_BITS       = 8;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] DIGIT_BAD  = 8'd127;
   localparam logic [7:0] LEN_MAX    = 8'd255;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_BIN = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_ALT = 2'd3
   } radix_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] number_value;
      logic                number_ok;
      logic                token_present;
      logic                line_done;
   } rsp_type;

   // Token state without the accumulator, whose width is a parameter
   typedef struct packed {
      logic                inside_token;
      logic [LEN_BITS-1:0] token_length;
      radix_type           radix_code;
      logic                token_failed;
      logic                prefix_taken;
      logic                x_prefix_taken;
   } tok_state_type;

   localparam tok_state_type TOK_CLEAR = '{
      inside_token:   1'b0,
      token_length:   '0,
      radix_code:     RADIX_DEC,
      token_failed:   1'b0,
      prefix_taken:   1'b0,
      x_prefix_taken: 1'b0
   };

   // Character to digit value, including the ':'..'@' -> 3..9 mapping
   function automatic logic [7:0] digit_of(input logic [7:0] c);
      logic [7:0] t;
      logic [7:0] d;
      t = c - CHAR_ZERO;
      if (t[7]) begin
         d = DIGIT_BAD;
      end else if (t < 8'd10) begin
         d = t;
      end else begin
         d = (t & 8'hDF) - 8'd7;
      end
      return d;
   endfunction

endpackage

FILE: rtl/ntp_step.sv
// Per-character token logic for the numeric token parser: next token state,
// next accumulator and the result for one character. Depends on ntp_pkg.
module ntp_step #(
   parameter int VALUE_BITS = ntp_pkg::VALUE_BITS_DEF
) (
   input  ntp_pkg::req_type       item,
   input  ntp_pkg::tok_state_type state_cur,
   input  logic [VALUE_BITS-1:0]  acc_cur,
   output ntp_pkg::tok_state_type state_nxt,
   output logic [VALUE_BITS-1:0]  acc_nxt,
   output logic                   rsp_fire,
   output ntp_pkg::rsp_type       rsp
);

   localparam int OUT_W = (VALUE_BITS < ntp_pkg::OUT_BITS) ? VALUE_BITS : ntp_pkg::OUT_BITS;

   logic                    sep;
   logic [7:0]              digit;
   logic [7:0]              radix_val;
   logic                    acc_zero;
   logic [VALUE_BITS-1:0]   acc_scaled;
   ntp_pkg::tok_state_type  st;
   logic [VALUE_BITS-1:0]   acc;
   logic                    ok;
   logic [ntp_pkg::OUT_BITS-1:0] val_out;

   assign sep      = (item.char_code == ntp_pkg::CHAR_SPACE) ||
                     (item.char_code == ntp_pkg::CHAR_TAB);
   assign digit    = ntp_pkg::digit_of(item.char_code);
   assign acc_zero = (acc_cur == '0);

   always_comb begin
      unique case (state_cur.radix_code)
         ntp_pkg::RADIX_BIN: begin
            radix_val  = 8'd2;
            acc_scaled = acc_cur << 1;
         end
         ntp_pkg::RADIX_HEX: begin
            radix_val  = 8'd16;
            acc_scaled = acc_cur << 4;
         end
         default: begin
            radix_val  = 8'd10;
            acc_scaled = (acc_cur << 3) + (acc_cur << 1);
         end
      endcase
   end

   // Update token state for a non-separator character
   always_comb begin
      st  = state_cur;
      acc = acc_cur;
      if (!sep) begin
         st.inside_token = 1'b1;
         if (state_cur.token_length != ntp_pkg::LEN_MAX) begin
            st.token_length = state_cur.token_length + 1'b1;
         end
         if (!state_cur.token_failed) begin
            priority if (acc_zero && state_cur.token_length <= 8'd1 &&
                         item.char_code == ntp_pkg::CHAR_B) begin
               st.radix_code = ntp_pkg::RADIX_BIN;
               if (state_cur.token_length == 8'd0) begin
                  st.prefix_taken = 1'b1;
               end
            end else if (acc_zero && state_cur.token_length == 8'd0 &&
                         item.char_code == ntp_pkg::CHAR_H) begin
               st.radix_code   = ntp_pkg::RADIX_HEX;
               st.prefix_taken = 1'b1;
            end else if (acc_zero && state_cur.token_length == 8'd1 &&
                         item.char_code == ntp_pkg::CHAR_X) begin
               st.radix_code     = ntp_pkg::RADIX_HEX;
               st.x_prefix_taken = 1'b1;
            end else if (digit < radix_val) begin
               acc = acc_scaled + VALUE_BITS'(digit);
            end else begin
               st.token_failed = 1'b1;
            end
         end
      end
   end

   assign ok = !st.token_failed &&
               !(st.prefix_taken && st.token_length == 8'd1) &&
               !(st.x_prefix_taken && st.token_length == 8'd2);

   assign val_out = ntp_pkg::OUT_BITS'(acc[OUT_W-1:0]);

   always_comb begin
      rsp_fire  = 1'b0;
      rsp       = '0;
      state_nxt = st;
      acc_nxt   = acc;
      priority if (st.inside_token && (sep || item.end_of_line)) begin
         rsp_fire          = 1'b1;
         rsp.number_value  = ok ? val_out : '0;
         rsp.number_ok     = ok;
         rsp.token_present = 1'b1;
         rsp.line_done     = item.end_of_line;
         state_nxt         = ntp_pkg::TOK_CLEAR;
         acc_nxt           = '0;
      end else if (item.end_of_line) begin
         // empty line end
         rsp_fire      = 1'b1;
         rsp.line_done = 1'b1;
         state_nxt     = ntp_pkg::TOK_CLEAR;
         acc_nxt       = '0;
      end else begin
         // mid-token or between tokens: no result
         rsp_fire = 1'b0;
      end
   end

endmodule

FILE: rtl/numeric_token_parser_top.sv
// Top level of the numeric token parser: input register, token state,
// result register. Depends on ntp_pkg and ntp_step.

// Streaming parser for whitespace-separated numbers on a command line, one
// byte per item, with 'b'/'h' prefixes and an 'x' prefix at the second byte.
// An item is registered on acceptance, parsed the next cycle by the
// per-character logic, and its result (if any) lands in the output register;
// one item per cycle is sustained. Throughput drops only while a result
// waits in the output register and the next item also produces one.
module numeric_token_parser_top #(
   parameter int VALUE_BITS = ntp_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ntp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ntp_pkg::rsp_type rsp_data
);

   logic                   in_valid_ff;
   ntp_pkg::req_type       in_data_ff;
   ntp_pkg::tok_state_type tok_ff, tok_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   out_valid_ff;
   ntp_pkg::rsp_type       out_data_ff;

   logic                   step_fire;
   ntp_pkg::rsp_type       step_rsp;
   logic                   out_free;
   logic                   advance;

   ntp_step #(
      .VALUE_BITS(VALUE_BITS)
   ) u_step (
      .item      (in_data_ff),
      .state_cur (tok_ff),
      .acc_cur   (acc_ff),
      .state_nxt (tok_in),
      .acc_nxt   (acc_in),
      .rsp_fire  (step_fire),
      .rsp       (step_rsp)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!step_fire || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= ntp_pkg::TOK_CLEAR;
         acc_ff <= '0;
      end else if (advance) begin
         tok_ff <= tok_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_fire) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_empty_only_at_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.token_present |-> rsp_data.line_done)
      else $error("result without token outside line end");

   a_ok_needs_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.number_ok |-> rsp_data.token_present)
      else $error("number_ok without token");

   a_bad_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.number_ok |-> rsp_data.number_value == '0)
      else $error("failed token carries nonzero value");

   a_no_result_at_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for numeric_token_parser_top: streams command-line bytes,
// predicts each token result and checks every result in order.
// Depends on ntp_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1750;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 250;
   localparam int MAX_PRINTS   = 100;

   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_W = 8'h57;
   localparam logic [7:0] LOWER_A = 8'h61;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ntp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ntp_pkg::rsp_type rsp_data;

   // bytes waiting to be sent; a set drain flag holds that byte until all results are in
   ntp_pkg::req_type line_chars_q[$];
   bit               drain_first_q[$];
   ntp_pkg::rsp_type token_results_q[$];

   // running token state of the parser
   bit                                 tok_open  = 1'b0;
   logic [ntp_pkg::LEN_BITS-1:0]       tok_len   = '0;
   ntp_pkg::radix_type                 tok_radix = ntp_pkg::RADIX_DEC;
   logic [ntp_pkg::VALUE_BITS_DEF-1:0] tok_acc   = '0;
   bit                                 tok_bad   = 1'b0;
   bit                                 tok_pfx   = 1'b0;
   bit                                 tok_xpfx  = 1'b0;

   ntp_pkg::rsp_type predicted_rsp;
   ntp_pkg::rsp_type expected_rsp;
   int      error_count  = 0;
   int      rsp_count    = 0;
   int      quiet_cycles = 0;
   int      gap_left     = 0;
   int      stall_left   = 0;
   int      req_calm     = 0;
   int      rsp_calm     = 0;
   bit      long_hold_done = 1'b0;

   numeric_token_parser_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("ERROR: %s", msg);
      end
   endtask

   // Mostly no gap, sometimes a short one, rarely a long one; calm runs have none
   function automatic int pick_idle(inout int calm_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 3) begin
         calm_left = $urandom_range(30, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Advance the token state by one byte; return 1 with the result if one is due
   function automatic bit parse_char(input ntp_pkg::req_type item,
                                     output ntp_pkg::rsp_type res);
      logic [7:0] c;
      logic [7:0] pos;
      logic [7:0] t;
      logic [7:0] dval;
      int         base;
      bit         is_sep;
      bit         took_prefix;
      bit         ok;
      c      = item.char_code;
      is_sep = (c == ntp_pkg::CHAR_SPACE) || (c == ntp_pkg::CHAR_TAB);
      res    = '0;
      if (!is_sep) begin
         pos      = tok_len;
         tok_open = 1'b1;
         if (tok_len != ntp_pkg::LEN_MAX) tok_len++;
         if (!tok_bad) begin
            took_prefix = 1'b0;
            // prefixes only count while nothing has been accumulated
            if (tok_acc == '0) begin
               if (pos <= 1 && c == ntp_pkg::CHAR_B) begin
                  tok_radix   = ntp_pkg::RADIX_BIN;
                  tok_pfx     = tok_pfx || (pos == 0);
                  took_prefix = 1'b1;
               end else if (pos == 0 && c == ntp_pkg::CHAR_H) begin
                  tok_radix   = ntp_pkg::RADIX_HEX;
                  tok_pfx     = 1'b1;
                  took_prefix = 1'b1;
               end else if (pos == 1 && c == ntp_pkg::CHAR_X) begin
                  tok_radix   = ntp_pkg::RADIX_HEX;
                  tok_xpfx    = 1'b1;
                  took_prefix = 1'b1;
               end
            end
            if (!took_prefix) begin
               unique case (tok_radix)
                  ntp_pkg::RADIX_BIN: base = 2;
                  ntp_pkg::RADIX_HEX: base = 16;
                  default:            base = 10;
               endcase
               t = c - ntp_pkg::CHAR_ZERO;
               if (t[7]) begin
                  dval = ntp_pkg::DIGIT_BAD;
               end else if (t < 8'd10) begin
                  dval = t;
               end else begin
                  // fold case, then letters start at ten; ':'..'@' land on 3..9
                  dval = {t[7:6], 1'b0, t[4:0]} - 8'd7;
               end
               if (dval < base) begin
                  tok_acc = ntp_pkg::VALUE_BITS_DEF'(tok_acc * base + dval);
               end else begin
                  tok_bad = 1'b1;
               end
            end
         end
      end
      if (tok_open && (is_sep || item.end_of_line)) begin
         ok = !tok_bad && !(tok_pfx && tok_len == 1) && !(tok_xpfx && tok_len == 2);
         res.number_value  = ok ? ntp_pkg::OUT_BITS'(tok_acc) : '0;
         res.number_ok     = ok;
         res.token_present = 1'b1;
         res.line_done     = item.end_of_line;
      end else if (item.end_of_line) begin
         res.line_done = 1'b1;
      end else begin
         return 1'b0;
      end
      tok_open  = 1'b0;
      tok_len   = '0;
      tok_radix = ntp_pkg::RADIX_DEC;
      tok_acc   = '0;
      tok_bad   = 1'b0;
      tok_pfx   = 1'b0;
      tok_xpfx  = 1'b0;
      return 1'b1;
   endfunction

   task automatic push_char(input logic [7:0] c, input bit eol, input bit drain);
      ntp_pkg::req_type item;
      item.char_code   = c;
      item.end_of_line = eol;
      line_chars_q.push_back(item);
      drain_first_q.push_back(drain);
   endtask

   task automatic queue_text(input string s, input bit close_line);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], close_line && (i == s.len() - 1), 1'b0);
      end
   endtask

   function automatic logic [7:0] sep_char();
      return ($urandom_range(0, 3) == 0) ? ntp_pkg::CHAR_TAB : ntp_pkg::CHAR_SPACE;
   endfunction

   function automatic logic [7:0] dec_char(input bit quirky);
      if (quirky && $urandom_range(0, 6) == 0)
         return 8'(ntp_pkg::CHAR_ZERO + $urandom_range(10, 16));
      return 8'(ntp_pkg::CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(ntp_pkg::CHAR_ZERO + v);
      case ($urandom_range(0, 4))
         0, 1:    return 8'(LOWER_A + v - 10);
         2, 3:    return 8'(UPPER_A + v - 10);
         default: return 8'(UPPER_W + $urandom_range(0, 2));
      endcase
   endfunction

   // Sender: predict on acceptance, then offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (parse_char(req_data, predicted_rsp)) token_results_q.push_back(predicted_rsp);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (line_chars_q.size() != 0 &&
                         !(drain_first_q[0] && token_results_q.size() != 0)) begin
               req_valid <= 1'b1;
               req_data  <= line_chars_q.pop_front();
               drain_first_q.delete(0);
               gap_left = pick_idle(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each result against the oldest prediction, then pick ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (token_results_q.size() == 0) begin
               flag_error($sformatf("result %0d with none expected: %h", rsp_count, rsp_data));
            end else begin
               expected_rsp = token_results_q.pop_front();
               if (rsp_data.number_value !== expected_rsp.number_value)
                  flag_error($sformatf("result %0d number_value %h, expected %h", rsp_count,
                                       rsp_data.number_value, expected_rsp.number_value));
               if (rsp_data.number_ok !== expected_rsp.number_ok)
                  flag_error($sformatf("result %0d number_ok %b, expected %b", rsp_count,
                                       rsp_data.number_ok, expected_rsp.number_ok));
               if (rsp_data.token_present !== expected_rsp.token_present)
                  flag_error($sformatf("result %0d token_present %b, expected %b", rsp_count,
                                       rsp_data.token_present, expected_rsp.token_present));
               if (rsp_data.line_done !== expected_rsp.line_done)
                  flag_error($sformatf("result %0d line_done %b, expected %b", rsp_count,
                                       rsp_data.line_done, expected_rsp.line_done));
            end
         end
         // one long hold-off so the parser backs up into its input
         if (!long_hold_done && rsp_count >= 100) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_idle(rsp_calm);
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("numeric_token_parser_top regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int         kind;
      int         n_tokens;
      int         directed_items;
      int         long_left;
      bit         line_drain;
      bit         mid_drain_done;
      logic [7:0] line_buf[$];

      // prefix alone, "0x" alone, "bb" then a separator closing the line
      queue_text("h ", 1'b0);
      queue_text("0x", 1'b1);
      queue_text("bb\t", 1'b1);
      queue_text("0b b", 1'b1);
      // colon-range digits, W as hex zero, extreme bytes, empty line, wrap
      queue_text(":@", 1'b1);
      queue_text("hWf", 1'b1);
      push_char(8'hFF, 1'b0, 1'b0);
      push_char(8'h00, 1'b1, 1'b0);
      queue_text(" ", 1'b1);
      queue_text("65537", 1'b1);
      directed_items = line_chars_q.size();

      long_left      = 2;
      line_drain     = 1'b1;
      mid_drain_done = 1'b0;
      while (line_chars_q.size() < directed_items + RANDOM_ITEMS) begin
         line_buf.delete();
         if ($urandom_range(0, 4) == 0) line_buf.push_back(sep_char());
         n_tokens = $urandom_range(0, 4);
         for (int k = 0; k < n_tokens; k++) begin
            if (k > 0) repeat ($urandom_range(1, 3)) line_buf.push_back(sep_char());
            kind = $urandom_range(0, 99);
            if (long_left > 0 &&
                (kind == 99 || line_chars_q.size() > directed_items + 1200)) begin
               // long token: the length count saturates
               long_left--;
               repeat ($urandom_range(256, 262)) line_buf.push_back(dec_char(1'b0));
            end else if (kind < 25) begin
               repeat ($urandom_range(1, 6)) line_buf.push_back(dec_char(1'b1));
            end else if (kind < 40) begin
               line_buf.push_back(ntp_pkg::CHAR_H);
               repeat ($urandom_range(0, 4)) line_buf.push_back(hex_char());
            end else if (kind < 55) begin
               line_buf.push_back(($urandom_range(0, 4) == 0) ? dec_char(1'b0)
                                                              : ntp_pkg::CHAR_ZERO);
               line_buf.push_back(ntp_pkg::CHAR_X);
               repeat ($urandom_range(0, 4)) line_buf.push_back(hex_char());
            end else if (kind < 70) begin
               if ($urandom_range(0, 1)) line_buf.push_back(ntp_pkg::CHAR_ZERO);
               line_buf.push_back(ntp_pkg::CHAR_B);
               repeat ($urandom_range(0, 12)) begin
                  line_buf.push_back(8'(ntp_pkg::CHAR_ZERO +
                     (($urandom_range(0, 19) == 0) ? 2 : $urandom_range(0, 1))));
               end
            end else if (kind < 80) begin
               // mixes of prefix letters and zeros
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(0, 4))
                     0:       line_buf.push_back(ntp_pkg::CHAR_B);
                     1:       line_buf.push_back(ntp_pkg::CHAR_H);
                     2:       line_buf.push_back(ntp_pkg::CHAR_X);
                     3:       line_buf.push_back(ntp_pkg::CHAR_ZERO);
                     default: line_buf.push_back(8'(ntp_pkg::CHAR_ZERO + 1));
                  endcase
               end
            end else if (kind < 92) begin
               repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 1)) begin
               repeat ($urandom_range(5, 7)) line_buf.push_back(dec_char(1'b0));
            end else begin
               line_buf.push_back(ntp_pkg::CHAR_H);
               repeat ($urandom_range(5, 6)) line_buf.push_back(hex_char());
            end
         end
         if ($urandom_range(0, 3) == 0 || line_buf.size() == 0) line_buf.push_back(sep_char());
         if (!mid_drain_done && line_chars_q.size() >= directed_items + RANDOM_ITEMS / 2) begin
            mid_drain_done = 1'b1;
            line_drain     = 1'b1;
         end
         for (int i = 0; i < line_buf.size(); i++) begin
            push_char(line_buf[i], i == line_buf.size() - 1, line_drain && i == 0);
         end
         line_drain = 1'b0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (line_chars_q.size() != 0 || req_valid) @(posedge clock);
      while (token_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (token_results_q.size() != 0) flag_error("results still expected at the end");
      if (error_count == 0) begin
         $display("numeric_token_parser_top regression: pass");
      end else begin
         $display("numeric_token_parser_top regression: fail");
      end
      $finish;
   end

endmodule
